// ----- hw/rtl/tfsc_pkg.sv -----
// Shared types, constants and register codes for the thermal fan speed controller.
// Used by the channel interfaces and every module of the block; depends on nothing.
package tfsc_pkg;

	localparam int unsigned TEMP_W    = 16;
	localparam int unsigned SPD_W     = 3;
	localparam int unsigned REG_W     = 16;
	localparam int unsigned REG_IDX_W = 3;
	localparam int unsigned NUM_FANS  = 3;
	localparam int unsigned NUM_SIDES = 2;

	// Highest fan speed; must stay within what SPD_W bits can hold.
	localparam int unsigned MAX_SPEED  = 5;
	// Width of the settle counters.
	localparam int unsigned CNT_W      = 16;
	// Side speed applied when automatic control is switched on.
	localparam int unsigned INIT_SPEED = 3;

	localparam logic [SPD_W-1:0] SPD_MAX  = SPD_W'(MAX_SPEED);
	localparam logic [SPD_W-1:0] SPD_INIT = SPD_W'(INIT_SPEED);

	// Fan order inside the per-fan arrays.
	localparam int unsigned FAN_RIGHT = 0;
	localparam int unsigned FAN_LEFT  = 1;
	localparam int unsigned FAN_TOP   = 2;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_THR_HIGH     = 3'd0,
		REG_THR_LOW      = 3'd1,
		REG_SIDE_RISK    = 3'd2,
		REG_TOP_RISK     = 3'd3,
		REG_TOP_NORM     = 3'd4,
		REG_SETTLE_TICKS = 3'd5
	} reg_idx_t;

	typedef struct packed {
		logic signed [TEMP_W-1:0] thr_high;
		logic signed [TEMP_W-1:0] thr_low;
		logic signed [TEMP_W-1:0] side_risk;
		logic signed [TEMP_W-1:0] top_risk;
		logic signed [TEMP_W-1:0] top_norm;
		logic        [REG_W-1:0]  settle_ticks;
	} cfg_t;

	typedef struct packed {
		logic signed [TEMP_W-1:0] temp_right;
		logic signed [TEMP_W-1:0] temp_left;
		logic signed [TEMP_W-1:0] temp_top;
		logic                     auto_on;
		logic        [SPD_W-1:0]  manual_right;
		logic        [SPD_W-1:0]  manual_left;
		logic        [SPD_W-1:0]  manual_top;
	} in_item_t;

	typedef struct packed {
		logic [SPD_W-1:0] right_cmd;
		logic [SPD_W-1:0] left_cmd;
		logic [SPD_W-1:0] top_cmd;
		logic             right_write;
		logic             left_write;
		logic             top_write;
		logic             rescuing;
	} out_item_t;

	// Controller state carried from one tick to the next.
	typedef struct packed {
		logic                              auto_prev;
		logic [NUM_FANS-1:0][SPD_W-1:0]    manual_cache;
		logic [NUM_SIDES-1:0][SPD_W-1:0]   auto_speed;
		logic [NUM_SIDES-1:0][CNT_W-1:0]   settle_count;
		logic [NUM_SIDES-1:0]              settling;
		logic [NUM_FANS-1:0]               rescue_active;
		logic [NUM_FANS-1:0][SPD_W-1:0]    saved_speed;
		logic [NUM_FANS-1:0][SPD_W-1:0]    applied_speed;
	} state_t;

endpackage

// ----- hw/rtl/tfsc_if.sv -----
// Valid/ready channel interfaces for sensor ticks and fan commands.
// Depends on tfsc_pkg for the payload types.
interface tfsc_in_if;
	import tfsc_pkg::*;

	logic     valid;
	logic     ready;
	in_item_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface tfsc_out_if;
	import tfsc_pkg::*;

	logic      valid;
	logic      ready;
	out_item_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// ----- hw/rtl/tfsc_cfg_regs.sv -----
// Threshold and settle-time register file with a plain write port.
// Depends on tfsc_pkg for the register codes and the cfg_t bundle.
module tfsc_cfg_regs (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [tfsc_pkg::REG_IDX_W-1:0]  cfg_index,
	input  logic [tfsc_pkg::REG_W-1:0]      cfg_data,
	output tfsc_pkg::cfg_t                  cfg
);
	import tfsc_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.thr_high     <= 16'sd700;
			cfg_q.thr_low      <= 16'sd500;
			cfg_q.side_risk    <= 16'sd850;
			cfg_q.top_risk     <= 16'sd850;
			cfg_q.top_norm     <= 16'sd600;
			cfg_q.settle_ticks <= 16'd10;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_THR_HIGH:     cfg_q.thr_high     <= cfg_data;
				REG_THR_LOW:      cfg_q.thr_low      <= cfg_data;
				REG_SIDE_RISK:    cfg_q.side_risk    <= cfg_data;
				REG_TOP_RISK:     cfg_q.top_risk     <= cfg_data;
				REG_TOP_NORM:     cfg_q.top_norm     <= cfg_data;
				REG_SETTLE_TICKS: cfg_q.settle_ticks <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ----- hw/rtl/tfsc_step.sv -----
// Next-state and result logic for one tick: rescue, automatic and manual control.
// Depends on tfsc_pkg for the state, configuration and payload types.
module tfsc_step (
	input  tfsc_pkg::state_t    st,
	input  tfsc_pkg::in_item_t  item,
	input  tfsc_pkg::cfg_t      cfg,
	output tfsc_pkg::state_t    st_next,
	output tfsc_pkg::out_item_t result
);
	import tfsc_pkg::*;

	logic signed [TEMP_W-1:0] temp     [NUM_FANS];
	logic signed [TEMP_W-1:0] risk     [NUM_FANS];
	logic signed [TEMP_W-1:0] end_thr  [NUM_FANS];
	logic        [SPD_W-1:0]  man      [NUM_FANS];
	logic        [CNT_W-1:0]  settle_lim;

	assign temp[FAN_RIGHT]    = item.temp_right;
	assign temp[FAN_LEFT]     = item.temp_left;
	assign temp[FAN_TOP]      = item.temp_top;
	assign risk[FAN_RIGHT]    = cfg.side_risk;
	assign risk[FAN_LEFT]     = cfg.side_risk;
	assign risk[FAN_TOP]      = cfg.top_risk;
	assign end_thr[FAN_RIGHT] = cfg.thr_low;
	assign end_thr[FAN_LEFT]  = cfg.thr_low;
	assign end_thr[FAN_TOP]   = cfg.top_norm;
	assign man[FAN_RIGHT]     = item.manual_right;
	assign man[FAN_LEFT]      = item.manual_left;
	assign man[FAN_TOP]       = item.manual_top;
	assign settle_lim         = CNT_W'(cfg.settle_ticks);

	always_comb begin
		state_t              nx;
		logic [NUM_FANS-1:0] wr;
		logic                resc;
		logic                rise;
		logic                fall;
		logic [SPD_W-1:0]    spd;
		logic [SPD_W-1:0]    cur_spd;
		logic                cur_settling;
		logic [CNT_W-1:0]    cnt_inc;

		nx           = st;
		wr           = '0;
		rise         = 1'b0;
		fall         = 1'b0;
		spd          = '0;
		cur_spd      = '0;
		cur_settling = 1'b0;
		cnt_inc      = '0;

		// Over-temperature rescue, independent per fan.
		for (int i = 0; i < NUM_FANS; i++) begin
			if (temp[i] > risk[i]) begin
				if (!st.rescue_active[i]) begin
					nx.saved_speed[i]   = st.applied_speed[i];
					nx.rescue_active[i] = 1'b1;
					nx.applied_speed[i] = SPD_MAX;
					wr[i]               = 1'b1;
				end
			end else if (st.rescue_active[i] && (temp[i] < end_thr[i])) begin
				nx.applied_speed[i] = st.saved_speed[i];
				nx.rescue_active[i] = 1'b0;
				wr[i]               = 1'b1;
			end
		end
		resc = |nx.rescue_active;

		if (!resc) begin
			rise         = !st.auto_prev && item.auto_on;
			fall         = st.auto_prev && !item.auto_on;
			nx.auto_prev = item.auto_on;
			if (item.auto_on) begin
				for (int s = 0; s < NUM_SIDES; s++) begin
					// Switching auto on restarts both sides from the initial speed.
					cur_spd      = rise ? SPD_INIT : st.auto_speed[s];
					cur_settling = rise ? 1'b0 : st.settling[s];
					cnt_inc      = (rise ? '0 : st.settle_count[s]) + CNT_W'(1);
					if (rise) begin
						nx.auto_speed[s]    = SPD_INIT;
						nx.settle_count[s]  = '0;
						nx.settling[s]      = 1'b0;
						nx.applied_speed[s] = SPD_INIT;
						wr[s]               = 1'b1;
					end
					// On the switch-on tick the right side is re-initialized after its
					// own step, so only the left side gets a step.
					if (!(rise && (s == FAN_RIGHT))) begin
						if (cur_settling) begin
							if (cnt_inc == settle_lim) begin
								nx.settling[s]     = 1'b0;
								nx.settle_count[s] = '0;
							end else begin
								nx.settle_count[s] = cnt_inc;
							end
						end else begin
							spd = cur_spd;
							if (temp[s] > cfg.thr_high) begin
								if (cur_spd != SPD_MAX) begin
									spd                = cur_spd + SPD_W'(1);
									nx.settling[s]     = 1'b1;
									nx.settle_count[s] = '0;
								end
							end else if (temp[s] < cfg.thr_low) begin
								if (cur_spd != '0) begin
									spd                = cur_spd - SPD_W'(1);
									nx.settling[s]     = 1'b1;
									nx.settle_count[s] = '0;
								end
							end
							if (spd != cur_spd) begin
								nx.auto_speed[s]    = spd;
								nx.applied_speed[s] = spd;
								wr[s]               = 1'b1;
							end
						end
					end
				end
			end else begin
				// Leaving auto invalidates the cache, so every fan is rewritten.
				for (int i = 0; i < NUM_FANS; i++) begin
					if (fall || (st.manual_cache[i] != man[i])) begin
						nx.applied_speed[i] = (man[i] > SPD_MAX) ? SPD_MAX : man[i];
						nx.manual_cache[i]  = man[i];
						wr[i]               = 1'b1;
					end
				end
			end
		end

		st_next            = nx;
		result.right_cmd   = nx.applied_speed[FAN_RIGHT];
		result.left_cmd    = nx.applied_speed[FAN_LEFT];
		result.top_cmd     = nx.applied_speed[FAN_TOP];
		result.right_write = wr[FAN_RIGHT];
		result.left_write  = wr[FAN_LEFT];
		result.top_write   = wr[FAN_TOP];
		result.rescuing    = resc;
	end

endmodule

// ----- hw/rtl/thermal_fan_speed_controller.sv -----
// Top level of the thermal fan speed controller: handshake, pipeline and state registers.
// Depends on tfsc_pkg, tfsc_if, tfsc_cfg_regs and tfsc_step.
//
// Usage:
// The sensor channel carries one transaction per tick: three temperatures, the auto
// flag and three manual speeds. For every accepted transaction the fan channel
// delivers exactly one transaction with the speed commanded to each fan, a write
// strobe per fan and the rescue flag. Results leave in the order the ticks arrived.
// A tick is captured in an input register on acceptance; once the output register
// is empty or being drained, the controller state is updated and the result is
// captured in the output register. Each tick passes through a single combinational
// step between these registers, so while the receiver keeps ready high one
// transaction per cycle is sustained in both directions.
// When the receiver stalls, the output register holds its result while the input
// register still accepts one more tick; only when both are full does the sensor
// channel drop ready. No result is dropped or repeated under stalls.
// The thresholds and settle time are written through the cfg_we/cfg_index/cfg_data
// port; indexes beyond the last register are ignored. Writes are expected only while
// no tick is in flight.
// The asynchronous reset loads the default thresholds, clears all fan state (speeds
// 0, side auto speeds 1, no rescue, manual mode) and empties both registers.
module thermal_fan_speed_controller (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [tfsc_pkg::REG_IDX_W-1:0] cfg_index,
	input  logic [tfsc_pkg::REG_W-1:0]     cfg_data,
	tfsc_in_if.sink                        sensor,
	tfsc_out_if.source                     fan
);
	import tfsc_pkg::*;

	cfg_t      cfg;
	in_item_t  item_s1;
	logic      valid_s1;
	out_item_t res_q;
	logic      res_valid_q;
	state_t    st_q;
	state_t    st_next;
	out_item_t res_next;
	logic      advance;

	tfsc_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	tfsc_step u_step (
		.st      (st_q),
		.item    (item_s1),
		.cfg     (cfg),
		.st_next (st_next),
		.result  (res_next)
	);

	// The held tick moves on whenever the output register is empty or being drained.
	assign advance      = valid_s1 && (!res_valid_q || fan.ready);
	assign sensor.ready = !valid_s1 || advance;
	assign fan.valid    = res_valid_q;
	assign fan.data     = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (sensor.valid && sensor.ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (sensor.valid && sensor.ready) begin
			item_s1 <= sensor.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= 1'b1;
		end else if (fan.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_next;
		end
	end

	// Controller state changes exactly once per tick, when its result is captured.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q.auto_prev     <= 1'b0;
			st_q.manual_cache  <= '0;
			for (int s = 0; s < NUM_SIDES; s++) begin
				st_q.auto_speed[s] <= SPD_W'(1);
			end
			st_q.settle_count  <= '0;
			st_q.settling      <= '0;
			st_q.rescue_active <= '0;
			st_q.saved_speed   <= '0;
			st_q.applied_speed <= '0;
		end else if (advance) begin
			st_q <= st_next;
		end
	end

	// A tick held in the input register is never lost while it waits.
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1)
		else $error("tick in input register was dropped");

	// A result flagged as rescuing matches the rescue state it left behind.
	a_rescue_state: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && res_q.rescuing |-> (st_q.rescue_active != '0))
		else $error("rescue flag without an active rescue");

	// Applied speeds never exceed the top speed.
	a_applied_max: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q.applied_speed[FAN_RIGHT] <= SPD_MAX) && (st_q.applied_speed[FAN_LEFT] <= SPD_MAX)
		&& (st_q.applied_speed[FAN_TOP] <= SPD_MAX))
		else $error("applied fan speed above maximum");

	// Automatic side speeds stay within range.
	a_auto_max: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q.auto_speed[FAN_RIGHT] <= SPD_MAX) && (st_q.auto_speed[FAN_LEFT] <= SPD_MAX))
		else $error("automatic side speed above maximum");

endmodule

// ----- tb/tfsc_command_checker.sv -----
`timescale 1ns / 100ps
// Checker for the thermal fan speed controller: watches the sensor, fan and register ports.
// Predicts the fan commands of every accepted tick and compares them in order.
// Depends on tfsc_pkg and the channel interfaces in tfsc_if.
module tfsc_command_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [tfsc_pkg::REG_IDX_W-1:0] cfg_index,
	input  logic [tfsc_pkg::REG_W-1:0]     cfg_data,
	tfsc_in_if                             sensor,
	tfsc_out_if                            fan,
	output int unsigned                    mismatches,
	output int unsigned                    backlog,
	output int unsigned                    results_checked
);
	import tfsc_pkg::*;

	localparam logic [7:0] CACHE_BLANK = 8'hFF;

	// Register copies.
	logic signed [TEMP_W-1:0] thr_high;
	logic signed [TEMP_W-1:0] thr_low;
	logic signed [TEMP_W-1:0] side_risk;
	logic signed [TEMP_W-1:0] top_risk;
	logic signed [TEMP_W-1:0] top_norm;
	logic        [REG_W-1:0]  settle_ticks;

	// Controller state as it should be after the last accepted tick. The manual
	// cache is a byte per fan so that the blank marker differs from every speed.
	logic             auto_prev;
	logic [7:0]       man_cache   [NUM_FANS];
	logic [SPD_W-1:0] auto_spd    [NUM_SIDES];
	logic [CNT_W-1:0] settle_cnt  [NUM_SIDES];
	logic             settling    [NUM_SIDES];
	logic             rescue_on   [NUM_FANS];
	logic [SPD_W-1:0] saved_spd   [NUM_FANS];
	logic [SPD_W-1:0] applied_spd [NUM_FANS];

	// Writes made during the tick being predicted.
	logic [SPD_W-1:0] tick_cmd [NUM_FANS];
	logic             tick_wr  [NUM_FANS];

	out_item_t fan_commands_due[$];

	function automatic void reset_model();
		thr_high     = 16'sd700;
		thr_low      = 16'sd500;
		side_risk    = 16'sd850;
		top_risk     = 16'sd850;
		top_norm     = 16'sd600;
		settle_ticks = 16'd10;
		auto_prev    = 1'b0;
		for (int i = 0; i < NUM_FANS; i++) begin
			man_cache[i]   = '0;
			rescue_on[i]   = 1'b0;
			saved_spd[i]   = '0;
			applied_spd[i] = '0;
		end
		for (int s = 0; s < NUM_SIDES; s++) begin
			auto_spd[s]   = SPD_W'(1);
			settle_cnt[s] = '0;
			settling[s]   = 1'b0;
		end
	endfunction

	function automatic void set_fan(int i, logic [SPD_W-1:0] spd);
		applied_spd[i] = spd;
		tick_cmd[i]    = spd;
		tick_wr[i]     = 1'b1;
	endfunction

	function automatic void rescue_check(int i, logic signed [TEMP_W-1:0] t,
			logic signed [TEMP_W-1:0] risk, logic signed [TEMP_W-1:0] stop);
		if (t > risk) begin
			if (!rescue_on[i]) begin
				saved_spd[i] = applied_spd[i];
				rescue_on[i] = 1'b1;
				set_fan(i, SPD_MAX);
			end
		end else if (rescue_on[i] && t < stop) begin
			set_fan(i, saved_spd[i]);
			rescue_on[i] = 1'b0;
		end
	endfunction

	// One side fan in auto mode. The init flag is honored on both calls of a
	// tick, so the right fan is reset a second time before the left one runs.
	function automatic void side_step(int s, logic signed [TEMP_W-1:0] t, logic init);
		logic [SPD_W-1:0] spd;
		if (init) begin
			for (int j = 0; j < NUM_SIDES; j++) begin
				auto_spd[j]   = SPD_INIT;
				settle_cnt[j] = '0;
				settling[j]   = 1'b0;
			end
			set_fan(FAN_RIGHT, SPD_INIT);
			set_fan(FAN_LEFT, SPD_INIT);
		end
		if (settling[s]) begin
			settle_cnt[s] = settle_cnt[s] + 1'b1;
			if (settle_cnt[s] == CNT_W'(settle_ticks)) begin
				settling[s]   = 1'b0;
				settle_cnt[s] = '0;
			end
			return;
		end
		spd = auto_spd[s];
		if (t > thr_high) begin
			if (spd != SPD_MAX) begin
				spd++;
				settling[s]   = 1'b1;
				settle_cnt[s] = '0;
			end
		end else if (t < thr_low) begin
			if (spd != '0) begin
				spd--;
				settling[s]   = 1'b1;
				settle_cnt[s] = '0;
			end
		end
		if (spd != auto_spd[s]) begin
			auto_spd[s] = spd;
			set_fan(s, spd);
		end
	endfunction

	function automatic out_item_t next_fan_commands(in_item_t tick);
		logic signed [TEMP_W-1:0] tr;
		logic signed [TEMP_W-1:0] tl;
		logic signed [TEMP_W-1:0] tt;
		logic [SPD_W-1:0]         man [NUM_FANS];
		logic                     any_rescue;
		logic                     rise;
		logic                     fall;
		out_item_t                r;
		tr = $signed(tick.temp_right);
		tl = $signed(tick.temp_left);
		tt = $signed(tick.temp_top);
		man[FAN_RIGHT] = tick.manual_right;
		man[FAN_LEFT]  = tick.manual_left;
		man[FAN_TOP]   = tick.manual_top;
		for (int i = 0; i < NUM_FANS; i++) begin
			tick_wr[i]  = 1'b0;
			tick_cmd[i] = '0;
		end

		rescue_check(FAN_RIGHT, tr, side_risk, thr_low);
		rescue_check(FAN_LEFT, tl, side_risk, thr_low);
		rescue_check(FAN_TOP, tt, top_risk, top_norm);
		any_rescue = rescue_on[FAN_RIGHT] | rescue_on[FAN_LEFT] | rescue_on[FAN_TOP];

		if (!any_rescue) begin
			rise      = !auto_prev && tick.auto_on;
			fall      = auto_prev && !tick.auto_on;
			auto_prev = tick.auto_on;
			if (tick.auto_on) begin
				side_step(FAN_RIGHT, tr, rise);
				side_step(FAN_LEFT, tl, rise);
			end else begin
				if (fall) begin
					for (int i = 0; i < NUM_FANS; i++)
						man_cache[i] = CACHE_BLANK;
				end
				for (int i = 0; i < NUM_FANS; i++) begin
					if (man_cache[i] != 8'(man[i])) begin
						set_fan(i, (man[i] > SPD_MAX) ? SPD_MAX : man[i]);
						man_cache[i] = 8'(man[i]);
					end
				end
			end
		end

		r.right_cmd   = tick_wr[FAN_RIGHT] ? tick_cmd[FAN_RIGHT] : applied_spd[FAN_RIGHT];
		r.left_cmd    = tick_wr[FAN_LEFT] ? tick_cmd[FAN_LEFT] : applied_spd[FAN_LEFT];
		r.top_cmd     = tick_wr[FAN_TOP] ? tick_cmd[FAN_TOP] : applied_spd[FAN_TOP];
		r.right_write = tick_wr[FAN_RIGHT];
		r.left_write  = tick_wr[FAN_LEFT];
		r.top_write   = tick_wr[FAN_TOP];
		r.rescuing    = any_rescue;
		return r;
	endfunction

	task automatic check_field(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, actual %0d", name, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		out_item_t want;
		out_item_t got;
		if (!arst_n) begin
			reset_model();
			fan_commands_due.delete();
			mismatches      = 0;
			results_checked = 0;
		end else begin
			// A result leaves only after its tick has passed through the input and output
			// registers, so the comparison can safely come before this edge's new tick.
			if (fan.valid && fan.ready) begin
				got = fan.data;
				if (fan_commands_due.size() == 0) begin
					$error("fan transaction %h arrived with no sensor tick pending", got);
					mismatches++;
				end else begin
					want = fan_commands_due.pop_front();
					results_checked++;
					check_field("right_cmd", want.right_cmd, got.right_cmd);
					check_field("left_cmd", want.left_cmd, got.left_cmd);
					check_field("top_cmd", want.top_cmd, got.top_cmd);
					check_field("right_write", want.right_write, got.right_write);
					check_field("left_write", want.left_write, got.left_write);
					check_field("top_write", want.top_write, got.top_write);
					check_field("rescuing", want.rescuing, got.rescuing);
				end
			end
			if (sensor.valid && sensor.ready)
				fan_commands_due.push_back(next_fan_commands(sensor.data));
			if (cfg_we) begin
				case (cfg_index)
					REG_THR_HIGH:     thr_high = cfg_data;
					REG_THR_LOW:      thr_low = cfg_data;
					REG_SIDE_RISK:    side_risk = cfg_data;
					REG_TOP_RISK:     top_risk = cfg_data;
					REG_TOP_NORM:     top_norm = cfg_data;
					REG_SETTLE_TICKS: settle_ticks = cfg_data;
					default: ;
				endcase
			end
		end
		backlog = fan_commands_due.size();
	end

endmodule

// ----- tb/thermal_fan_speed_controller_tb.sv -----
`timescale 1ns / 100ps
// Top of the thermal fan speed controller testbench: clock, reset, stimulus and verdict.
// Depends on tfsc_pkg, tfsc_if, the controller RTL and tfsc_command_checker.
module thermal_fan_speed_controller_tb;
	import tfsc_pkg::*;

	// The slowest correct run waits out a long sender gap and a long receiver
	// stall on every one of roughly 1050 ticks. The limit leaves several times
	// that margin.
	localparam int unsigned CYCLE_LIMIT = 600_000;

	// Indexes past the last register; writes to them must change nothing.
	localparam logic [REG_IDX_W-1:0] REG_SPARE_FIRST = REG_IDX_W'(REG_SETTLE_TICKS) + 1'b1;
	localparam logic [REG_IDX_W-1:0] REG_SPARE_LAST  = '1;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 cfg_we;
	logic [REG_IDX_W-1:0] cfg_index;
	logic [REG_W-1:0]     cfg_data;

	tfsc_in_if  sensor_ch ();
	tfsc_out_if fan_ch ();

	int unsigned mismatches;
	int unsigned backlog;
	int unsigned results_checked;
	int unsigned ticks_sent;

	// While calm is set, neither side idles, so the block sees back-to-back
	// transactions in both directions.
	bit calm;

	// Current operator inputs; random ticks mostly repeat them so that the
	// manual cache and the auto mode get long stable runs.
	bit               cur_auto;
	logic [SPD_W-1:0] cur_man [NUM_FANS];

	// Register values as last written, used to aim temperatures at thresholds.
	int c_high;
	int c_low;
	int c_side;
	int c_top;
	int c_norm;

	thermal_fan_speed_controller u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.sensor    (sensor_ch),
		.fan       (fan_ch)
	);

	tfsc_command_checker u_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.sensor          (sensor_ch),
		.fan             (fan_ch),
		.mismatches      (mismatches),
		.backlog         (backlog),
		.results_checked (results_checked)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Idle lengths: none while calm is set, else mostly none or short, now and then a long one.
	function automatic int unsigned pick_gap();
		int unsigned r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Speeds above the maximum are legal inputs and must be saturated, so they
	// appear now and then.
	function automatic logic [SPD_W-1:0] pick_speed();
		if ($urandom_range(0, 99) < 85)
			return SPD_W'($urandom_range(0, MAX_SPEED));
		return SPD_W'($urandom_range(MAX_SPEED + 1, (1 << SPD_W) - 1));
	endfunction

	// A temperature that mostly falls in the band around the hysteresis
	// thresholds, often lands right on a threshold, and sometimes is an
	// extreme or a fully random word.
	function automatic logic [TEMP_W-1:0] pick_temp(int lo, int hi, int risk);
		int r;
		int v;
		int span;
		int base;
		r = $urandom_range(0, 99);
		if (r < 10)
			return TEMP_W'($urandom);
		if (r < 16) begin
			case ($urandom_range(0, 3))
				0: v = -32768;
				1: v = 32767;
				2: v = 0;
				default: v = -1;
			endcase
		end else if (r < 40) begin
			case ($urandom_range(0, 2))
				0: v = lo;
				1: v = hi;
				default: v = risk;
			endcase
			v += int'($urandom_range(0, 6)) - 3;
		end else begin
			span = (hi > lo) ? hi - lo : lo - hi;
			if (span > 2000)
				span = 2000;
			base = ((hi < lo) ? hi : lo) - 100;
			v = base + int'($urandom_range(0, span + 200));
		end
		if (v < -32768)
			v = -32768;
		if (v > 32767)
			v = 32767;
		return TEMP_W'(v);
	endfunction

	function automatic in_item_t mk_tick(int tr, int tl, int tt, bit a, int mr, int ml, int mt);
		in_item_t it;
		it.temp_right   = TEMP_W'(tr);
		it.temp_left    = TEMP_W'(tl);
		it.temp_top     = TEMP_W'(tt);
		it.auto_on      = a;
		it.manual_right = SPD_W'(mr);
		it.manual_left  = SPD_W'(ml);
		it.manual_top   = SPD_W'(mt);
		return it;
	endfunction

	function automatic in_item_t random_tick();
		in_item_t it;
		if ($urandom_range(0, 99) < 6)
			cur_auto = !cur_auto;
		for (int i = 0; i < NUM_FANS; i++) begin
			if ($urandom_range(0, 99) < 25)
				cur_man[i] = pick_speed();
		end
		it.temp_right   = pick_temp(c_low, c_high, c_side);
		it.temp_left    = pick_temp(c_low, c_high, c_side);
		it.temp_top     = pick_temp(c_norm, c_high, c_top);
		it.auto_on      = cur_auto;
		it.manual_right = cur_man[FAN_RIGHT];
		it.manual_left  = cur_man[FAN_LEFT];
		it.manual_top   = cur_man[FAN_TOP];
		return it;
	endfunction

	// Presents one tick and holds it until the block takes it. After the
	// transaction, valid either stays high for the next tick or drops for a
	// random gap; it is never lowered and raised at the same edge.
	task automatic send_tick(input in_item_t it);
		int unsigned gap;
		@(negedge clk);
		sensor_ch.valid <= 1'b1;
		sensor_ch.data  <= it;
		@(posedge clk);
		while (!sensor_ch.ready)
			@(posedge clk);
		ticks_sent++;
		gap = pick_gap();
		if (gap > 0) begin
			@(negedge clk);
			sensor_ch.valid <= 1'b0;
			repeat (gap - 1)
				@(negedge clk);
		end
	endtask

	// Stops sending and waits until every predicted result has been taken.
	// Each tick yields exactly one result, so an empty backlog means idle.
	task automatic drain();
		@(negedge clk);
		sensor_ch.valid <= 1'b0;
		wait (backlog == 0);
	endtask

	task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [REG_W-1:0] value);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(negedge clk);
		cfg_we    <= 1'b0;
	endtask

	task automatic apply_setting(int hi, int lo, int side, int top, int norm, int settle);
		write_reg(REG_THR_HIGH, REG_W'(hi));
		write_reg(REG_THR_LOW, REG_W'(lo));
		write_reg(REG_SIDE_RISK, REG_W'(side));
		write_reg(REG_TOP_RISK, REG_W'(top));
		write_reg(REG_TOP_NORM, REG_W'(norm));
		write_reg(REG_SETTLE_TICKS, REG_W'(settle));
		c_high = hi;
		c_low  = lo;
		c_side = side;
		c_top  = top;
		c_norm = norm;
	endtask

	// Random ticks, with calm stretches switched on and off every 40 ticks.
	task automatic run_random(int unsigned count);
		for (int unsigned n = 0; n < count; n++) begin
			if (n % 40 == 0)
				calm = ($urandom_range(0, 3) == 0);
			send_tick(random_tick());
		end
		calm = 1'b0;
	endtask

	// The receiver holds ready high for a random stretch, then stalls for a
	// random gap, for the whole run.
	initial begin
		int unsigned stall;
		fan_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			fan_ch.ready <= 1'b1;
			repeat ($urandom_range(0, 15))
				@(negedge clk);
			stall = pick_gap();
			if (stall > 0) begin
				@(negedge clk);
				fan_ch.ready <= 1'b0;
				repeat (stall - 1)
					@(negedge clk);
			end
		end
	end

	// A run that hangs, whether on a handshake or on a result that never
	// arrives, ends here.
	initial begin
		int unsigned cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("Run stopped after %0d cycles with %0d results outstanding", cycles, backlog);
		$display("Some tests failed");
		$finish;
	end

	initial begin
		arst_n          = 1'b0;
		cfg_we          = 1'b0;
		cfg_index       = '0;
		cfg_data        = '0;
		sensor_ch.valid = 1'b0;
		sensor_ch.data  = '0;
		calm            = 1'b0;
		cur_auto        = 1'b0;
		ticks_sent      = 0;
		for (int i = 0; i < NUM_FANS; i++)
			cur_man[i] = '0;
		c_high = 700;
		c_low  = 500;
		c_side = 850;
		c_top  = 850;
		c_norm = 600;

		repeat (7)
			@(negedge clk);
		arst_n <= 1'b1;

		// Directed ticks under the reset thresholds (raise above 700, lower
		// below 500, rescue above 850, top rescue ends below 600, settle 10).
		// Manual mode first: a speed equal to the cleared cache writes nothing,
		// new speeds are written, and speeds above the maximum saturate.
		send_tick(mk_tick(0, 0, 0, 0, 0, 0, 0));
		send_tick(mk_tick(0, 0, 0, 0, 5, 5, 5));
		send_tick(mk_tick(0, 0, 0, 0, 7, 6, 7));
		send_tick(mk_tick(0, 0, 0, 0, 7, 6, 7));
		// Entering auto sets both sides to 3; then both step up and settle.
		send_tick(mk_tick(600, 600, 0, 1, 7, 6, 7));
		send_tick(mk_tick(750, 750, 0, 1, 7, 6, 7));
		send_tick(mk_tick(750, 750, 0, 1, 7, 6, 7));
		// Leaving auto invalidates the cache, so every fan is rewritten.
		send_tick(mk_tick(400, 400, 0, 0, 1, 2, 3));
		// Right rescue, a mode switch that must wait while the rescue holds,
		// and the restore that lets the switch into auto happen.
		send_tick(mk_tick(900, 0, 0, 0, 1, 2, 3));
		send_tick(mk_tick(800, 0, 0, 1, 1, 2, 3));
		send_tick(mk_tick(499, 0, 0, 1, 1, 2, 3));
		// Top rescue and its end exactly at and just below the normal mark.
		send_tick(mk_tick(0, 0, 900, 1, 1, 2, 3));
		send_tick(mk_tick(0, 0, 600, 1, 1, 2, 3));
		send_tick(mk_tick(0, 0, 599, 1, 1, 2, 3));
		// Extreme temperatures put each fan in rescue and release it again.
		send_tick(mk_tick(32767, -32768, 32767, 1, 1, 2, 3));
		send_tick(mk_tick(-32768, -32768, -32768, 0, 0, 0, 0));
		send_tick(mk_tick(32767, 32767, -32768, 1, 7, 7, 7));
		send_tick(mk_tick(500, 500, 599, 1, 7, 7, 7));
		send_tick(mk_tick(-1, -1, 0, 1, 7, 7, 7));
		send_tick(mk_tick(0, 0, 0, 1, 7, 7, 7));
		drain();

		// Random phases, each under its own register setting. The block is
		// idle at every change because the previous phase has drained.
		apply_setting(700, 500, 850, 850, 600, 3);
		run_random(200);
		drain();

		// Widest thresholds: no step and no rescue can ever start.
		apply_setting(32767, -32768, 32767, 32767, -32768, 1);
		run_random(160);
		drain();

		// Narrowest thresholds: nearly every tick rescues, and a settle time
		// of zero would wait the full counter range.
		apply_setting(-32768, 32767, -32768, -32768, 32767, 0);
		run_random(60);
		drain();

		// Longest settle time: after one step a side stays put.
		apply_setting(300, 200, 1000, 900, 100, 65535);
		run_random(200);
		drain();

		// Tight thresholds that overlap, plus writes past the last register
		// that would upset them if they were not ignored.
		apply_setting(100, 100, 200, 150, 140, 2);
		write_reg(REG_SPARE_FIRST, 16'h8000);
		write_reg(REG_SPARE_LAST, 16'h0000);
		run_random(220);
		drain();

		// Negative thresholds and a one-tick settle time.
		apply_setting(-50, -200, 400, 300, -100, 1);
		run_random(190);
		drain();

		// Any result that shows up after the last one expected is still caught.
		repeat (8)
			@(posedge clk);

		$display("Sent %0d sensor ticks over six threshold settings and checked %0d results,",
			ticks_sent, results_checked);
		$display("with random idling on both channels and calm back-to-back stretches.");
		if (mismatches == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
